// File: rtl/core/cssc_pkg.sv
// shared types, constants and byte-class lookup for the source syntax checker
package cssc_pkg;

  localparam int COUNT_BITS = 24;
  localparam int DEPTH_BITS = 16;

  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_CTRL_MAX = 8'h1f;

  localparam logic [255:0] WORD_CLASS = {
    ~32'hffe00000, ~32'h00000003, 32'hffffffff, 32'hffffffff,
    ~32'hb8000000, ~32'h38000001, ~32'h780093cd, 32'h00000000
  };

  typedef enum logic [3:0] {
    M_TOP       = 4'd0,
    M_WORD      = 4'd1,
    M_AT        = 4'd2,
    M_ANN_FIRST = 4'd3,
    M_ANN_WORD  = 4'd4,
    M_TXT_FIRST = 4'd5,
    M_INLINE    = 4'd6,
    M_ML_START  = 4'd7,
    M_ML_LINE   = 4'd8
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic [COUNT_BITS-1:0] cnt;
    logic [COUNT_BITS-1:0] ppos;
    logic [COUNT_BITS-1:0] apos;
    logic [DEPTH_BITS-1:0] depth;
    logic                  stopped;
    logic                  ovf;
  } parse_state_t;

  typedef struct packed {
    logic                  halted;
    logic [COUNT_BITS-1:0] scanned;
    logic [COUNT_BITS-1:0] parsed;
    logic [COUNT_BITS-1:0] accepted;
    logic [DEPTH_BITS-1:0] depth;
    logic                  overflow;
    logic                  whole;
  } status_t;

  localparam parse_state_t STATE_RESET = '{
    mode: M_TOP, cnt: '0, ppos: '0, apos: '0, depth: '0, stopped: 1'b0, ovf: 1'b0
  };

  function automatic logic is_word(input logic [7:0] b);
    return WORD_CLASS[b];
  endfunction

endpackage

// File: rtl/core/cssc_step.sv
// one-byte parse transition: next state and status word
module cssc_step (
  input  cssc_pkg::parse_state_t st,
  input  logic [7:0]             data_byte,
  input  logic                   last,
  output cssc_pkg::parse_state_t st_nxt,
  output cssc_pkg::status_t      status
);

  cssc_pkg::parse_state_t             nx;
  logic                               tk;
  logic                               ts;
  logic                               w;
  logic [cssc_pkg::COUNT_BITS-1:0]    cnt_inc;
  logic                               whole;

  always_comb begin
    nx      = st;
    tk      = 1'b0;
    ts      = 1'b0;
    whole   = 1'b0;
    w       = cssc_pkg::is_word(data_byte);
    cnt_inc = (&st.cnt) ? st.cnt : st.cnt + 1'b1;

    if (!st.stopped) begin
      unique case (st.mode)
        cssc_pkg::M_WORD: begin
          if (w) begin
            tk = 1'b1;
          end else if (data_byte == cssc_pkg::CH_AT) begin
            tk = 1'b1;
            nx.mode = cssc_pkg::M_AT;
          end else begin
            ts = 1'b1;
          end
        end
        cssc_pkg::M_AT: begin
          if (w) begin
            tk = 1'b1;
            nx.mode = cssc_pkg::M_WORD;
          end else begin
            nx.stopped = 1'b1;
          end
        end
        cssc_pkg::M_ANN_FIRST: begin
          if (w) begin
            tk = 1'b1;
            nx.mode = cssc_pkg::M_ANN_WORD;
          end else begin
            nx.stopped = 1'b1;
          end
        end
        cssc_pkg::M_ANN_WORD: begin
          if (w) begin
            tk = 1'b1;
          end else if (data_byte == cssc_pkg::CH_RPAREN) begin
            tk = 1'b1;
            nx.mode = cssc_pkg::M_WORD;
          end else begin
            nx.stopped = 1'b1;
          end
        end
        cssc_pkg::M_TXT_FIRST: begin
          if (data_byte == cssc_pkg::CH_NL) begin
            tk = 1'b1;
            nx.mode = cssc_pkg::M_ML_START;
          end else if (data_byte == cssc_pkg::CH_QUOTE) begin
            tk = 1'b1;
            nx.mode = cssc_pkg::M_WORD;
          end else if (data_byte > cssc_pkg::CH_CTRL_MAX) begin
            tk = 1'b1;
            nx.mode = cssc_pkg::M_INLINE;
          end else begin
            nx.stopped = 1'b1;
          end
        end
        cssc_pkg::M_INLINE: begin
          if (data_byte == cssc_pkg::CH_QUOTE) begin
            tk = 1'b1;
            nx.mode = cssc_pkg::M_WORD;
          end else if (data_byte > cssc_pkg::CH_CTRL_MAX) begin
            tk = 1'b1;
          end else begin
            nx.stopped = 1'b1;
          end
        end
        cssc_pkg::M_ML_START: begin
          if (data_byte == cssc_pkg::CH_NL) begin
            tk = 1'b1;
          end else if (data_byte == cssc_pkg::CH_SPACE) begin
            tk = 1'b1;
            nx.mode = cssc_pkg::M_ML_LINE;
          end else if (data_byte == cssc_pkg::CH_QUOTE) begin
            tk = 1'b1;
            nx.mode = cssc_pkg::M_WORD;
          end else begin
            nx.stopped = 1'b1;
          end
        end
        cssc_pkg::M_ML_LINE: begin
          if (data_byte > cssc_pkg::CH_CTRL_MAX) begin
            tk = 1'b1;
          end else if (data_byte == cssc_pkg::CH_NL) begin
            tk = 1'b1;
            nx.mode = cssc_pkg::M_ML_START;
          end else begin
            nx.stopped = 1'b1;
          end
        end
        default: begin
          ts = 1'b1;
        end
      endcase
    end

    // token start: byte always counted first
    if (ts) begin
      tk = 1'b1;
      if (w) begin
        nx.mode = cssc_pkg::M_WORD;
      end else if (data_byte == cssc_pkg::CH_SPACE || data_byte == cssc_pkg::CH_NL) begin
        nx.ppos = cnt_inc;
        if (st.depth == '0) begin
          nx.apos = cnt_inc;
        end
        nx.mode = cssc_pkg::M_TOP;
      end else if (data_byte == cssc_pkg::CH_LBRACK) begin
        if (&st.depth) begin
          nx.ovf     = 1'b1;
          nx.stopped = 1'b1;
        end else begin
          nx.depth = st.depth + 1'b1;
        end
        nx.mode = cssc_pkg::M_TOP;
      end else if (data_byte == cssc_pkg::CH_RBRACK && st.depth != '0) begin
        nx.depth = st.depth - 1'b1;
        nx.mode  = cssc_pkg::M_WORD;
      end else if (data_byte == cssc_pkg::CH_LPAREN) begin
        nx.mode = cssc_pkg::M_ANN_FIRST;
      end else if (data_byte == cssc_pkg::CH_QUOTE) begin
        nx.mode = cssc_pkg::M_TXT_FIRST;
      end else begin
        nx.stopped = 1'b1;
      end
    end

    if (tk) begin
      nx.cnt = cnt_inc;
    end

    if (last) begin
      if (!nx.stopped && nx.mode != cssc_pkg::M_TOP && nx.mode != cssc_pkg::M_WORD) begin
        nx.stopped = 1'b1;
      end
      whole = !nx.stopped && (nx.apos == nx.cnt);
    end

    status.halted   = nx.stopped;
    status.scanned  = nx.cnt;
    status.parsed   = nx.ppos;
    status.accepted = nx.apos;
    status.depth    = nx.depth;
    status.overflow = nx.ovf;
    status.whole    = whole;

    st_nxt = last ? cssc_pkg::STATE_RESET : nx;
  end

endmodule

// File: rtl/core/concatenative_source_syntax_checker.sv
// top level: input register, parse state and status output register
//
// Streaming syntax checker for source text. The input channel (in_valid,
// in_ready) carries one source byte per word with a last flag that closes
// the message. The output channel (out_valid, out_ready) returns one status
// word per input byte: halted, scanned/parsed/accepted counts, block depth,
// depth overflow and, on the last byte, whether the whole message was
// accepted.
// The byte is captured in an input register when it is accepted, then the
// parse transition runs combinationally from it into the status register.
// Throughput is one byte per cycle while the receiver does not stall; the
// only loop is the parse state register fed back through the transition
// logic. The parse state returns to its start after each last byte.
// Reset (rst_n low, synchronous) empties both registers and clears the
// parse state. When the receiver stalls, the status register holds its
// word, the input register holds one more byte, and in_ready drops only
// when both are full.
module concatenative_source_syntax_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_halted,
  output logic [cssc_pkg::COUNT_BITS-1:0] out_scanned_count,
  output logic [cssc_pkg::COUNT_BITS-1:0] out_parsed_count,
  output logic [cssc_pkg::COUNT_BITS-1:0] out_accepted_count,
  output logic [cssc_pkg::DEPTH_BITS-1:0] out_block_depth,
  output logic                            out_depth_overflow,
  output logic                            out_whole_accepted
);

  logic                   in_valid_r;
  logic [7:0]             in_byte_r;
  logic                   in_last_r;
  logic                   out_valid_r;
  cssc_pkg::parse_state_t state_r;
  cssc_pkg::parse_state_t state_nxt;
  cssc_pkg::status_t      status_r;
  cssc_pkg::status_t      status_nxt;
  logic                   adv;

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  cssc_step u_step (
    .st        (state_r),
    .data_byte (in_byte_r),
    .last      (in_last_r),
    .st_nxt    (state_nxt),
    .status    (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= cssc_pkg::STATE_RESET;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last;
    end
    if (adv) begin
      status_r <= status_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_halted         = status_r.halted;
  assign out_scanned_count  = status_r.scanned;
  assign out_parsed_count   = status_r.parsed;
  assign out_accepted_count = status_r.accepted;
  assign out_block_depth    = status_r.depth;
  assign out_depth_overflow = status_r.overflow;
  assign out_whole_accepted = status_r.whole;

endmodule
